### sv/cswf_pkg.sv
`timescale 1ns / 1ps
package cswf_pkg;

   // Window geometry
   localparam int WINDOW   = 8;
   localparam int CHANNELS = 2;

   // Field widths
   localparam int CH_W     = 1;
   localparam int CODE_W   = 12;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 15;
   localparam int MA_W     = 16;

   // Derived widths
   localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int ADDR_W   = (CHANNELS * WINDOW > 1) ? $clog2(CHANNELS * WINDOW) : 1;
   localparam int SUM_W    = MA_W + $clog2(WINDOW);
   localparam int ABS_W    = SUM_W - 1;
   localparam int RECIP_K  = ABS_W;
   localparam int RECIP_W  = RECIP_K + 1;
   localparam int QPROD_W  = ABS_W + RECIP_W;
   localparam int PROD_W   = CODE_W + GAIN_W;
   localparam int MAG_W    = PROD_W + 1 - 8;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CODE_W-1:0]  ZERO_CODE_RST = CODE_W'(2048);
   localparam logic [GAIN_W-1:0]  GAIN_RST      = GAIN_W'(1114);
   localparam logic [LIMIT_W-1:0] DEADBAND_RST  = LIMIT_W'(50);
   localparam logic [LIMIT_W-1:0] CLAMP_RST     = LIMIT_W'(5000);

   typedef enum logic [1:0] {
      CSR_ZERO_CODE,
      CSR_GAIN_Q8,
      CSR_DEADBAND,
      CSR_CLAMP
   } csr_index_type;

   typedef struct packed {
      logic [CODE_W-1:0]  zero_code;
      logic [GAIN_W-1:0]  gain_q8;
      logic [LIMIT_W-1:0] deadband_ma;
      logic [LIMIT_W-1:0] clamp_ma;
   } cfg_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SAT,
      ST_ACC,
      ST_QEST,
      ST_FIX
   } state_type;

   // Step strobes from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic mul;
      logic sat;
      logic acc;
      logic qest;
      logic load;
   } cmd_type;

endpackage

### sv/cswf_if.sv
`timescale 1ns / 1ps
interface cswf_req_if;
   import cswf_pkg::*;
   logic              valid;
   logic              ready;
   logic [CH_W-1:0]   channel;
   logic [CODE_W-1:0] sample_code;

   modport source (output valid, output channel, output sample_code, input ready);
   modport sink   (input valid, input channel, input sample_code, output ready);
endinterface

interface cswf_rsp_if;
   import cswf_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CH_W-1:0]        channel_out;
   logic signed [MA_W-1:0] instant_ma;
   logic signed [MA_W-1:0] filtered_ma;
   logic                   window_full;

   modport source (output valid, output channel_out, output instant_ma,
                   output filtered_ma, output window_full, input ready);
   modport sink   (input valid, input channel_out, input instant_ma,
                   input filtered_ma, input window_full, output ready);
endinterface

### sv/cswf_csr.sv
`timescale 1ns / 1ps
module cswf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cswf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cswf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cswf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output cswf_pkg::cfg_type                   cfg
);
   import cswf_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index      = csr_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_ZERO_CODE: cfg_in.zero_code   = csr_pwdata[CODE_W-1:0];
            CSR_GAIN_Q8:   cfg_in.gain_q8     = csr_pwdata[GAIN_W-1:0];
            CSR_DEADBAND:  cfg_in.deadband_ma = csr_pwdata[LIMIT_W-1:0];
            CSR_CLAMP:     cfg_in.clamp_ma    = csr_pwdata[LIMIT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_code   <= ZERO_CODE_RST;
         cfg_ff.gain_q8     <= GAIN_RST;
         cfg_ff.deadband_ma <= DEADBAND_RST;
         cfg_ff.clamp_ma    <= CLAMP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (index)
         CSR_ZERO_CODE: csr_prdata = CSR_DATA_W'(cfg_ff.zero_code);
         CSR_GAIN_Q8:   csr_prdata = CSR_DATA_W'(cfg_ff.gain_q8);
         CSR_DEADBAND:  csr_prdata = CSR_DATA_W'(cfg_ff.deadband_ma);
         CSR_CLAMP:     csr_prdata = CSR_DATA_W'(cfg_ff.clamp_ma);
         default:       csr_prdata = '0;
      endcase
   end

endmodule

### sv/cswf_ctrl.sv
`timescale 1ns / 1ps
module cswf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cswf_pkg::cmd_type cmd
);
   import cswf_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and step strobes
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_QEST;
         end
         ST_QEST: begin
            cmd.qest = 1'b1;
            state_in = ST_FIX;
         end
         ST_FIX: begin
            // hold until the output register is free, then take the next request
            if (out_free) begin
               cmd.load  = 1'b1;
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_MUL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load | (rsp_valid_ff & ~rsp_ready);

endmodule

### sv/cswf_dp.sv
`timescale 1ns / 1ps
module cswf_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  cswf_pkg::cmd_type                  cmd,
   input  cswf_pkg::cfg_type                  cfg,
   input  logic [cswf_pkg::CH_W-1:0]          req_channel,
   input  logic [cswf_pkg::CODE_W-1:0]        req_sample_code,
   output logic [cswf_pkg::CH_W-1:0]          rsp_channel_out,
   output logic signed [cswf_pkg::MA_W-1:0]   rsp_instant_ma,
   output logic signed [cswf_pkg::MA_W-1:0]   rsp_filtered_ma,
   output logic                               rsp_window_full
);
   import cswf_pkg::*;

   // Request capture
   logic [CH_W-1:0]   ch_ff;
   logic [CODE_W-1:0] code_ff;

   // Conversion
   logic                   neg_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic signed [MA_W-1:0] inst_ff;
   logic signed [MA_W-1:0] old_ff;

   // Per-channel ring state
   logic signed [MA_W-1:0]  window_mem [CHANNELS*WINDOW];
   logic signed [SUM_W-1:0] sum_ff  [CHANNELS];
   logic [PTR_W-1:0]        pos_ff  [CHANNELS];
   logic [CNT_W-1:0]        fill_ff [CHANNELS];

   // Divide
   logic [ABS_W-1:0]   abs_ff;
   logic               sneg_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [QPROD_W-1:0] qprod_ff;
   logic [RECIP_W-1:0] recip_tab [WINDOW+1];

   // Output register
   logic [CH_W-1:0]        out_ch_ff;
   logic signed [MA_W-1:0] out_inst_ff;
   logic signed [MA_W-1:0] out_filt_ff;
   logic                   out_full_ff;

   logic                    ch_ok;
   logic [ADDR_W-1:0]       mem_addr;
   logic signed [CODE_W:0]  diff;
   logic [CODE_W-1:0]       absd;
   logic [PROD_W-1:0]       prod_in;
   logic [MAG_W-1:0]        mag;
   logic [LIMIT_W-1:0]      mag_lim;
   logic signed [MA_W-1:0]  inst_in;
   logic                    was_full;
   logic signed [SUM_W-1:0] sum_in;
   logic [CNT_W-1:0]        fill_in;
   logic [PTR_W-1:0]        pos_in;
   logic [ABS_W-1:0]        abs_in;
   logic [QPROD_W-1:0]      qprod_in;
   logic [ABS_W-1:0]        q_est;
   logic [ABS_W-1:0]        q_times_n;
   logic [ABS_W-1:0]        rem;
   logic [ABS_W-1:0]        q_fix;
   logic signed [MA_W-1:0]  filt_in;
   logic                    full_in;

   // Reciprocal table, floor(2^K / n)
   assign recip_tab[0] = '0;
   for (genvar i = 1; i <= WINDOW; i++) begin : g_recip
      localparam longint RecipVal = (longint'(1) << RECIP_K) / i;
      assign recip_tab[i] = RECIP_W'(RecipVal);
   end

   assign ch_ok    = (int'(ch_ff) < CHANNELS);
   assign mem_addr = ADDR_W'(ADDR_W'(ch_ff) * ADDR_W'(WINDOW)) + ADDR_W'(pos_ff[ch_ff]);
   assign was_full = (fill_ff[ch_ff] == CNT_W'(WINDOW));

   // Offset removal and gain multiply
   always_comb begin
      diff    = $signed({1'b0, code_ff}) - $signed({1'b0, cfg.zero_code});
      absd    = diff[CODE_W] ? CODE_W'(-diff) : CODE_W'(diff);
      prod_in = PROD_W'(absd) * PROD_W'(cfg.gain_q8);
   end

   // Round, deadband, clamp, apply sign
   always_comb begin
      mag = MAG_W'(((PROD_W+1)'(prod_ff) + (PROD_W+1)'(128)) >> 8);
      if (mag < MAG_W'(cfg.deadband_ma)) begin
         mag_lim = '0;
      end else if (mag > MAG_W'(cfg.clamp_ma)) begin
         mag_lim = cfg.clamp_ma;
      end else begin
         mag_lim = LIMIT_W'(mag);
      end
      inst_in = neg_ff ? -MA_W'(mag_lim) : MA_W'(mag_lim);
   end

   // Running window sum: add the new entry, drop the one it overwrites
   always_comb begin
      sum_in = sum_ff[ch_ff] + SUM_W'(inst_ff);
      if (was_full) begin
         sum_in = sum_in - SUM_W'(old_ff);
      end
      fill_in = was_full ? fill_ff[ch_ff] : fill_ff[ch_ff] + CNT_W'(1);
      pos_in  = (pos_ff[ch_ff] == PTR_W'(WINDOW - 1)) ? '0 : pos_ff[ch_ff] + PTR_W'(1);
      abs_in  = sum_in[SUM_W-1] ? ABS_W'(-sum_in) : ABS_W'(sum_in);
   end

   // Quotient estimate by reciprocal, then one correction step
   always_comb begin
      qprod_in  = QPROD_W'(abs_ff) * QPROD_W'(recip_tab[n_ff]);
      q_est     = qprod_ff[RECIP_K +: ABS_W];
      q_times_n = ABS_W'(q_est * ABS_W'(n_ff));
      rem       = abs_ff - q_times_n;
      q_fix     = (rem >= ABS_W'(n_ff)) ? q_est + ABS_W'(1) : q_est;
      if (ch_ok) begin
         filt_in = sneg_ff ? -MA_W'(q_fix) : MA_W'(q_fix);
         full_in = (n_ff == CNT_W'(WINDOW));
      end else begin
         filt_in = inst_ff;
         full_in = 1'b0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff   <= req_channel;
         code_ff <= req_sample_code;
      end
      if (cmd.mul) begin
         neg_ff  <= diff[CODE_W];
         prod_ff <= prod_in;
         old_ff  <= window_mem[mem_addr];
      end
      if (cmd.sat) begin
         inst_ff <= inst_in;
      end
      if (cmd.acc) begin
         abs_ff  <= abs_in;
         sneg_ff <= sum_in[SUM_W-1];
         n_ff    <= fill_in;
         if (ch_ok) begin
            window_mem[mem_addr] <= inst_ff;
         end
      end
      if (cmd.qest) begin
         qprod_ff <= qprod_in;
      end
      if (cmd.load) begin
         out_ch_ff   <= ch_ff;
         out_inst_ff <= inst_ff;
         out_filt_ff <= filt_in;
         out_full_ff <= full_in;
      end
   end

   // Per-channel ring control
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c]  <= '0;
            pos_ff[c]  <= '0;
            fill_ff[c] <= '0;
         end
      end else if (cmd.acc && ch_ok) begin
         sum_ff[ch_ff]  <= sum_in;
         pos_ff[ch_ff]  <= pos_in;
         fill_ff[ch_ff] <= fill_in;
      end
   end

   assign rsp_channel_out = out_ch_ff;
   assign rsp_instant_ma  = out_inst_ff;
   assign rsp_filtered_ma = out_filt_ff;
   assign rsp_window_full = out_full_ff;

endmodule

### sv/current_sense_window_filter.sv
`timescale 1ns / 1ps
// Current sense window filter.
// A request on req_bus carries a channel number and a raw 12-bit ADC code.
// The block removes the zero-current code, scales to milliamps with the Q8
// gain, applies deadband and clamp, and returns on rsp_bus the instantaneous
// current, the mean of the channel's last WINDOW currents (mean of what has
// been written while the window fills) and a window-full flag.
// Each request runs through the controller's step sequence (gain multiply,
// saturate, window update, reciprocal multiply, quotient correction) before
// its result moves into the output register; a new request is taken only
// while idle or in the cycle the result moves into the output register.
// When the receiver stalls, the finished result waits in the output register
// and the block holds its last step until that register frees up.
// Reset (synchronous) empties both windows and loads the default settings;
// the user must change settings through the csr_ port only while no request
// is pending, as the block itself does not enforce this.
module current_sense_window_filter (
   input  logic                                clock,
   input  logic                                reset,
   cswf_req_if.sink                            req_bus,
   cswf_rsp_if.source                          rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cswf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cswf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cswf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import cswf_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   cswf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cswf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   cswf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg),
      .req_channel     (req_bus.channel),
      .req_sample_code (req_bus.sample_code),
      .rsp_channel_out (rsp_bus.channel_out),
      .rsp_instant_ma  (rsp_bus.instant_ma),
      .rsp_filtered_ma (rsp_bus.filtered_ma),
      .rsp_window_full (rsp_bus.window_full)
   );

endmodule
